// File: src/dds_pkg.sv
// Shared types and constants for the differential drive wheel speed shaper.
package dds_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MWH,
        S_MV,
        S_MVK,
        S_SUM,
        S_MG,
        S_ABS,
        S_DIV,
        S_DIFF,
        S_RAMP,
        S_MA,
        S_MB,
        S_ACC,
        S_RND,
        S_CLAMP,
        S_FIN
    } state_t;

    // Register indexes on the write port
    localparam logic [2:0] CFG_HALF_TRACK = 3'd0;
    localparam logic [2:0] CFG_RPM_GAIN   = 3'd1;
    localparam logic [2:0] CFG_LEFT_REV   = 3'd2;
    localparam logic [2:0] CFG_RIGHT_REV  = 3'd3;
    localparam logic [2:0] CFG_MAX_STEP   = 3'd4;
    localparam logic [2:0] CFG_ALPHA      = 3'd5;
    localparam logic [2:0] CFG_MAX_RPM    = 3'd6;

    // Reset values of the registers
    localparam logic [10:0] RST_HALF_TRACK = 11'd250;
    localparam logic [15:0] RST_RPM_GAIN   = 16'd51200;
    localparam logic [15:0] RST_MAX_STEP   = 16'd154;
    localparam logic [15:0] RST_ALPHA      = 16'd19661;
    localparam logic [14:0] RST_MAX_RPM    = 15'd300;

    // mm to um
    localparam logic [16:0] MM_TO_UM  = 17'd1000;
    // 256e6 = 2^14 * 15625; the power of two is a shift, 1/15625 is this
    // reciprocal in Q42, exact for dividends below 2^29
    localparam logic [28:0] RPM_RECIP = 29'd281474977;
    // Unity weight in Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    // Half LSB for the two roundings
    localparam logic [44:0] HALF_Q16  = 45'd32768;
    localparam logic [23:0] HALF_Q8   = 24'd128;

endpackage

// File: src/diff_drive_wheel_speed_shaper.sv
// Differential drive wheel speed shaper: kinematics, ramp, smoother, clamp.
// One item at a time: in_stall stays high from taking an item until its result is
// registered. A sequencer drives one shared 30x30 multiplier: three shared
// steps, then twelve per wheel, the rpm division being a single reciprocal product.
// A stalled result holds the sequencer in its final step. Reset (rst_n low, async)
// restores register defaults, clears ramp and smoother state, drops result valid.
module diff_drive_wheel_speed_shaper
    import dds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] linear_speed,
    input  logic signed [15:0] turn_rate,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_rpm,
    output logic signed [15:0] right_rpm
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] half_track_reg;
    logic [15:0] rpm_gain_reg;
    logic        left_rev_reg;
    logic        right_rev_reg;
    logic [15:0] max_step_reg;
    logic [15:0] alpha_reg;
    logic [14:0] max_rpm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_track_reg <= RST_HALF_TRACK;
            rpm_gain_reg   <= RST_RPM_GAIN;
            left_rev_reg   <= 1'b0;
            right_rev_reg  <= 1'b0;
            max_step_reg   <= RST_MAX_STEP;
            alpha_reg      <= RST_ALPHA;
            max_rpm_reg    <= RST_MAX_RPM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_TRACK: half_track_reg <= cfg_data[10:0];
                CFG_RPM_GAIN:   rpm_gain_reg   <= cfg_data;
                CFG_LEFT_REV:   left_rev_reg   <= cfg_data[0];
                CFG_RIGHT_REV:  right_rev_reg  <= cfg_data[0];
                CFG_MAX_STEP:   max_step_reg   <= cfg_data;
                CFG_ALPHA:      alpha_reg      <= cfg_data;
                CFG_MAX_RPM:    max_rpm_reg    <= cfg_data[14:0];
                default:        ; // unused index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   sel_reg, sel_next;                 // 0 left wheel, 1 right wheel

    logic signed [15:0] v_reg, v_next;
    logic signed [15:0] w_reg, w_next;
    logic signed [44:0] prod_reg, prod_next;   // multiplier output register
    logic signed [44:0] acc_reg, acc_next;     // smoother sum
    logic signed [26:0] wh_reg, wh_next;       // w * half track
    logic signed [25:0] vk_reg, vk_next;       // v * 1000, um/s
    logic signed [27:0] s_reg, s_next;         // signed track speed, um/s
    logic        [28:0] y_reg, y_next;         // |s*gain| >> 14
    logic        [14:0] q_reg, q_next;         // target magnitude, whole rpm
    logic               sign_reg, sign_next;
    logic signed [23:0] tq_reg, tq_next;       // target in Q.8
    logic signed [24:0] d_reg, d_next;         // target minus ramp
    logic        [44:0] mag_reg, mag_next;
    logic        [22:0] cm_reg, cm_next;       // clamped smoother magnitude
    logic signed [15:0] left_hold_reg, left_hold_next;

    // Per-wheel state, Q.8 rpm
    logic signed [23:0] ramp_reg [2];
    logic signed [23:0] ramp_next [2];
    logic signed [23:0] smooth_reg [2];
    logic signed [23:0] smooth_next [2];

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] left_rpm_reg, left_rpm_next;
    logic signed [15:0] right_rpm_reg, right_rpm_next;

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [29:0] mul_a;
    logic        [28:0] mul_b;
    logic signed [59:0] mul_full;

    assign mul_full = mul_a * $signed({1'b0, mul_b});

    // Helpers
    logic signed [23:0] ramp_cur;
    logic signed [23:0] smooth_cur;
    logic               rev_cur;
    logic               out_free;
    logic        [22:0] lim;

    assign ramp_cur   = ramp_reg[sel_reg];
    assign smooth_cur = smooth_reg[sel_reg];
    assign rev_cur    = sel_reg ? right_rev_reg : left_rev_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign lim        = {max_rpm_reg, 8'd0};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MWH;
            S_MWH:   state_next = S_MV;
            S_MV:    state_next = S_MVK;
            S_MVK:   state_next = S_SUM;
            S_SUM:   state_next = S_MG;
            S_MG:    state_next = S_ABS;
            S_ABS:   state_next = S_DIV;
            S_DIV:   state_next = S_DIFF;
            S_DIFF:  state_next = S_RAMP;
            S_RAMP:  state_next = S_MA;
            S_MA:    state_next = S_MB;
            S_MB:    state_next = S_ACC;
            S_ACC:   state_next = S_RND;
            S_RND:   state_next = S_CLAMP;
            S_CLAMP: state_next = S_FIN;
            S_FIN:
            begin
                if (!sel_reg)
                    state_next = S_SUM;
                else if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: stall and multiplier operands
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            S_MWH:
            begin
                mul_a = 30'(w_reg);
                mul_b = 29'(half_track_reg);
            end
            S_MV:
            begin
                mul_a = 30'(v_reg);
                mul_b = 29'(MM_TO_UM);
            end
            S_MG:
            begin
                mul_a = 30'(s_reg);
                mul_b = 29'(rpm_gain_reg);
            end
            S_DIV:
            begin
                // floor(y / 15625) as a Q42 reciprocal product
                mul_a = $signed({1'b0, y_reg});
                mul_b = RPM_RECIP;
            end
            S_MA:
            begin
                mul_a = 30'(ramp_cur);
                mul_b = 29'(alpha_reg);
            end
            S_MB:
            begin
                mul_a = 30'(smooth_cur);
                mul_b = 29'(ALPHA_ONE - 17'(alpha_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [27:0] vk_term;
    logic signed [27:0] wh_term;
    logic        [44:0] prod_mag;
    logic signed [23:0] tq_val;
    logic signed [24:0] step_s;
    logic        [44:0] rnd_sum;
    logic        [24:0] qm;
    logic        [22:0] cm_val;
    logic signed [23:0] cm_s;
    logic        [23:0] rpm_sum;
    logic signed [15:0] rpm_mag;
    logic signed [15:0] rpm_val;

    always_comb
    begin
        // Left track v - w*h, right v + w*h, each negated when reversed
        vk_term  = rev_cur ? -28'(vk_reg) : 28'(vk_reg);
        wh_term  = (sel_reg ^ rev_cur) ? 28'(wh_reg) : -28'(wh_reg);

        prod_mag = prod_reg[44] ? 45'(-prod_reg) : 45'(prod_reg);

        tq_val   = sign_reg ? -$signed({1'b0, q_reg, 8'd0})
                            :  $signed({1'b0, q_reg, 8'd0});
        step_s   = $signed({9'd0, max_step_reg});

        rnd_sum  = mag_reg + HALF_Q16;
        qm       = rnd_sum[40:16];
        cm_val   = (qm > 25'(lim)) ? lim : qm[22:0];
        cm_s     = $signed({1'b0, cm_val});

        rpm_sum  = {1'b0, cm_reg} + HALF_Q8;
        rpm_mag  = $signed(rpm_sum[23:8]);
        rpm_val  = sign_reg ? -rpm_mag : rpm_mag;

        v_next         = v_reg;
        w_next         = w_reg;
        sel_next       = sel_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        wh_next        = wh_reg;
        vk_next        = vk_reg;
        s_next         = s_reg;
        y_next         = y_reg;
        q_next         = q_reg;
        sign_next      = sign_reg;
        tq_next        = tq_reg;
        d_next         = d_reg;
        mag_next       = mag_reg;
        cm_next        = cm_reg;
        left_hold_next = left_hold_reg;
        ramp_next      = ramp_reg;
        smooth_next    = smooth_reg;
        left_rpm_next  = left_rpm_reg;
        right_rpm_next = right_rpm_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    v_next   = linear_speed;
                    w_next   = turn_rate;
                    sel_next = 1'b0;
                    if (restart)
                    begin
                        ramp_next[0]   = '0;
                        ramp_next[1]   = '0;
                        smooth_next[0] = '0;
                        smooth_next[1] = '0;
                    end
                end
            end
            S_MWH: prod_next = mul_full[44:0];
            S_MV:
            begin
                wh_next   = prod_reg[26:0];
                prod_next = mul_full[44:0];
            end
            S_MVK: vk_next = prod_reg[25:0];
            S_SUM: s_next = vk_term + wh_term;
            S_MG:  prod_next = mul_full[44:0];
            S_ABS:
            begin
                // |s*gain| stays below 2^43, so the shifted value fits 29 bits
                sign_next = prod_reg[44];
                y_next    = prod_mag[42:14];
            end
            S_DIV: q_next = mul_full[56:42];
            S_DIFF:
            begin
                tq_next = tq_val;
                d_next  = 25'(tq_val) - 25'(ramp_cur);
            end
            S_RAMP:
            begin
                if (d_reg <= step_s && d_reg >= -step_s)
                    ramp_next[sel_reg] = tq_reg;
                else if (d_reg > 25'sd0)
                    ramp_next[sel_reg] = 24'(25'(ramp_cur) + step_s);
                else
                    ramp_next[sel_reg] = 24'(25'(ramp_cur) - step_s);
            end
            S_MA:  prod_next = mul_full[44:0];
            S_MB:
            begin
                acc_next  = prod_reg;
                prod_next = mul_full[44:0];
            end
            S_ACC: acc_next = acc_reg + prod_reg;
            S_RND:
            begin
                sign_next = acc_reg[44];
                mag_next  = acc_reg[44] ? 45'(-acc_reg) : 45'(acc_reg);
            end
            S_CLAMP:
            begin
                // Round half away on the magnitude, then clamp symmetrically
                cm_next = cm_val;
                smooth_next[sel_reg] = sign_reg ? -cm_s : cm_s;
            end
            S_FIN:
            begin
                if (!sel_reg)
                begin
                    left_hold_next = rpm_val;
                    sel_next       = 1'b1;
                end
                else if (out_free)
                begin
                    left_rpm_next  = left_hold_reg;
                    right_rpm_next = rpm_val;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ramp_reg[0]   <= '0;
            ramp_reg[1]   <= '0;
            smooth_reg[0] <= '0;
            smooth_reg[1] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            ramp_reg      <= ramp_next;
            smooth_reg    <= smooth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        w_reg         <= w_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        wh_reg        <= wh_next;
        vk_reg        <= vk_next;
        s_reg         <= s_next;
        y_reg         <= y_next;
        q_reg         <= q_next;
        sign_reg      <= sign_next;
        tq_reg        <= tq_next;
        d_reg         <= d_next;
        mag_reg       <= mag_next;
        cm_reg        <= cm_next;
        left_hold_reg <= left_hold_next;
        left_rpm_reg  <= left_rpm_next;
        right_rpm_reg <= right_rpm_next;
    end

    assign out_valid = out_valid_reg;
    assign left_rpm  = left_rpm_reg;
    assign right_rpm = right_rpm_reg;

`ifndef SYNTHESIS
    // A taken item starts the sequence at once
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MWH))
        else $error("item taken but sequencer did not start");

    // The reciprocal product takes a single step
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIFF))
        else $error("rpm division did not finish in one step");

    // Clamped magnitude never exceeds the limit in force at the clamp
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAMP) |=> (cm_reg <= $past(lim)))
        else $error("smoother magnitude above clamp limit");

    // A result appears only from the right wheel's final step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN && sel_reg))
        else $error("result raised outside the final step");
`endif

endmodule

// File: tb/sv/wheel_rpm_checker.sv
// Checker for the wheel speed shaper: mirrors the registers, predicts wheel rpm, compares.
module wheel_rpm_checker
    import dds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] linear_speed,
    input  logic signed [15:0] turn_rate,
    input  logic               restart,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] left_rpm,
    input  logic signed [15:0] right_rpm,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UM_PER_MM   = 1000;
    localparam longint RPM_DIVISOR = 256000000;
    localparam longint Q16_ONE     = 65536;
    localparam longint Q8_ONE      = 256;
    localparam int     SHOW_MAX    = 10;
    localparam int     LEFT        = 0;
    localparam int     RIGHT       = 1;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } wheel_pair_t;

    // register mirror
    logic [10:0] cfg_track;
    logic [15:0] cfg_gain;
    logic        cfg_lrev;
    logic        cfg_rrev;
    logic [15:0] cfg_step;
    logic [15:0] cfg_alpha;
    logic [14:0] cfg_limit;

    // ramp and smoother state per wheel, Q.8 rpm
    longint wheel_ramp [2];
    longint wheel_smooth [2];

    wheel_pair_t rpm_expected [$];
    int          fail_count;

    // nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] step_wheel(input int side, input longint speed_um,
                                                      input logic rev);
        longint s, tgt, tq, d, stp, lim, sm, alpha, rnd;
        s = rev ? -speed_um : speed_um;
        tq = cfg_gain;
        tgt = (s * tq) / RPM_DIVISOR;
        tq = tgt * Q8_ONE;
        d = tq - wheel_ramp[side];
        stp = cfg_step;
        lim = cfg_limit;
        lim = lim * Q8_ONE;
        alpha = cfg_alpha;
        if (d <= stp && d >= -stp)
            wheel_ramp[side] = tq;
        else if (d > 0)
            wheel_ramp[side] = wheel_ramp[side] + stp;
        else
            wheel_ramp[side] = wheel_ramp[side] - stp;
        sm = round_div(wheel_smooth[side] * (Q16_ONE - alpha) + wheel_ramp[side] * alpha,
                       Q16_ONE);
        if (sm > lim)
            sm = lim;
        if (sm < -lim)
            sm = -lim;
        wheel_smooth[side] = sm;
        rnd = round_div(sm, Q8_ONE);
        return rnd[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        longint      v_mm;
        longint      w_mrad;
        longint      wh;
        wheel_pair_t want;
        wheel_pair_t got;
        if (!rst_n)
        begin
            cfg_track = RST_HALF_TRACK;
            cfg_gain  = RST_RPM_GAIN;
            cfg_lrev  = 1'b0;
            cfg_rrev  = 1'b0;
            cfg_step  = RST_MAX_STEP;
            cfg_alpha = RST_ALPHA;
            cfg_limit = RST_MAX_RPM;
            for (int i = 0; i < 2; i++)
            begin
                wheel_ramp[i] = 0;
                wheel_smooth[i] = 0;
            end
            rpm_expected.delete();
            fail_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HALF_TRACK: cfg_track = cfg_data[10:0];
                    CFG_RPM_GAIN:   cfg_gain  = cfg_data;
                    CFG_LEFT_REV:   cfg_lrev  = cfg_data[0];
                    CFG_RIGHT_REV:  cfg_rrev  = cfg_data[0];
                    CFG_MAX_STEP:   cfg_step  = cfg_data;
                    CFG_ALPHA:      cfg_alpha = cfg_data;
                    CFG_MAX_RPM:    cfg_limit = cfg_data[14:0];
                    default: ;
                endcase
            end

            // retire the older expectation before queueing a new one
            if (out_valid && !out_stall)
            begin
                got.left  = left_rpm;
                got.right = right_rpm;
                if (rpm_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("%0t: unexpected result left %0d right %0d",
                                 $realtime, got.left, got.right);
                end
                else
                begin
                    want = rpm_expected.pop_front();
                    if (got.left !== want.left || got.right !== want.right)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
                                     $realtime, want.left, got.left, want.right, got.right);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (restart)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        wheel_ramp[i] = 0;
                        wheel_smooth[i] = 0;
                    end
                end
                v_mm = linear_speed;
                w_mrad = turn_rate;
                wh = cfg_track;
                wh = wh * w_mrad;
                want.left  = step_wheel(LEFT, v_mm * UM_PER_MM - wh, cfg_lrev);
                want.right = step_wheel(RIGHT, v_mm * UM_PER_MM + wh, cfg_rrev);
                rpm_expected.push_back(want);
            end

            errors  <= fail_count;
            pending <= rpm_expected.size();
        end
    end

endmodule

// File: tb/sv/tb_diff_drive_wheel_speed_shaper.sv
// Top of the wheel speed shaper testbench: clock, reset, stimulus and verdict.
module tb_diff_drive_wheel_speed_shaper
    import dds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling: ~1800 items plus worst gaps and stalls,
    // taken several times over.
    localparam int CYCLE_LIMIT   = 1000000;
    // Settle time after the last result.
    localparam int TAIL_CYCLES   = 60;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 125;
    // Index 7 has no register behind it; writes there must be ignored.
    localparam logic [2:0] CFG_SPARE = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = CFG_HALF_TRACK;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] linear_speed = '0;
    logic signed [15:0] turn_rate = '0;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] left_rpm;
    logic signed [15:0] right_rpm;

    int errors;
    int pending;

    // Idling switches, changed per phase; both off for the closing stretch.
    logic sender_idles = 1'b0;
    logic receiver_idles = 1'b0;
    int   stall_left = 0;
    int   cycle_count = 0;

    always #5 clk = ~clk;

    diff_drive_wheel_speed_shaper u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_rpm     (left_rpm),
        .right_rpm    (right_rpm)
    );

    wheel_rpm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_rpm     (left_rpm),
        .right_rpm    (right_rpm),
        .errors       (errors),
        .pending      (pending)
    );

    // Result side back-pressure: stall bursts at random starts,
    // so they land on every step of the sequence.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (receiver_idles && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one item; returns at the edge where it is taken. The payload holds
    // still while stalled. An optional idle burst comes first.
    task automatic send_tick(input logic signed [15:0] v, input logic signed [15:0] w,
                             input logic rs);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        linear_speed <= v;
        turn_rate <= w;
        restart <= rs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has been seen.
    // The first edge lets the checker count an item taken at the current edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Full register set, written back to back while the block is idle,
    // plus a stray write to the unused index.
    task automatic load_settings(input logic [10:0] ht, input logic [15:0] gain,
                                 input logic lrev, input logic rrev,
                                 input logic [15:0] step, input logic [15:0] alpha,
                                 input logic [14:0] limit);
        wait_drained();
        write_reg(CFG_HALF_TRACK, {5'd0, ht});
        write_reg(CFG_RPM_GAIN, gain);
        write_reg(CFG_LEFT_REV, {15'd0, lrev});
        write_reg(CFG_RIGHT_REV, {15'd0, rrev});
        write_reg(CFG_MAX_STEP, step);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_MAX_RPM, {1'b0, limit});
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Register value biased toward the ends of its range and toward small values.
    function automatic logic [15:0] pick_reg(input logic [15:0] top_val,
                                             input logic [15:0] small_cap);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return top_val;
            2, 3:    return 16'($urandom_range(1, small_cap));
            default: return 16'($urandom_range(0, top_val));
        endcase
    endfunction

    // Speed or turn rate: mostly moderate, with full-range and extreme values.
    function automatic logic signed [15:0] pick_motion();
        case ($urandom_range(0, 7))
            0, 1:    return 16'($urandom);
            2:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            3:       return '0;
            default: return 16'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    initial
    begin : stimulus
        logic signed [15:0] v;
        logic signed [15:0] w;
        int                 sent;
        int                 hold;
        int                 mode;
        int                 drain_at;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset defaults, full-scale commands both ways
        send_tick(16'sd0, 16'sd0, 1'b0);
        send_tick(16'sd1000, 16'sd0, 1'b0);
        send_tick(16'sh7fff, 16'sd0, 1'b0);
        send_tick(16'sh7fff, 16'sd0, 1'b0);
        send_tick(16'sh8000, 16'sd0, 1'b0);
        send_tick(16'sd0, 16'sh7fff, 1'b0);
        send_tick(16'sd0, 16'sh8000, 1'b0);
        send_tick(16'sh7fff, 16'sh7fff, 1'b1);
        send_tick(16'sh8000, 16'sh8000, 1'b0);

        // every register at its top, both wheels reversed
        load_settings(11'd2047, 16'hffff, 1'b1, 1'b1, 16'hffff, 16'hffff, 15'h7fff);
        send_tick(16'sh7fff, 16'sh8000, 1'b0);
        send_tick(16'sh8000, 16'sh7fff, 1'b0);
        send_tick(-16'sd1, -16'sd1, 1'b0);
        send_tick(16'sh7fff, 16'sh7fff, 1'b1);

        // every register at zero: zero clamp forces zero output
        load_settings('0, '0, 1'b0, 1'b0, '0, '0, '0);
        send_tick(16'sd12345, -16'sd321, 1'b0);
        send_tick(16'sh8000, 16'sh7fff, 1'b1);

        // ramp frozen and smoother frozen: only the clamp acts
        load_settings(11'd250, 16'd51200, 1'b0, 1'b1, '0, '0, 15'd100);
        send_tick(16'sd1000, 16'sd100, 1'b0);
        send_tick(16'sd1000, 16'sd100, 1'b1);
        send_tick(16'sd0, 16'sd0, 1'b0);

        // instant ramp and full-weight smoother straight into a low clamp
        load_settings(11'd250, 16'd51200, 1'b1, 1'b0, 16'hffff, 16'hffff, 15'd300);
        send_tick(16'sd5000, -16'sd200, 1'b0);
        send_tick(-16'sd5000, 16'sd300, 1'b0);
        send_tick(16'sd500, 16'sd0, 1'b1);

        // ---- random phases, fresh settings each time
        drain_at = $urandom_range(10, PHASE_ITEMS - 10);
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_settings(11'(pick_reg(16'd2047, 16'd400)),
                          pick_reg(16'hffff, 16'd60000),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_reg(16'hffff, 16'd2000),
                          pick_reg(16'hffff, 16'd20000),
                          15'(pick_reg(16'h7fff, 16'd600)));

            // idling mixes; the closing phases run flat out
            mode = (phase >= RANDOM_PHASES - 2) ? 0 : $urandom_range(0, 3);
            sender_idles <= (mode == 1 || mode == 3);
            receiver_idles <= (mode == 2 || mode == 3);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // Mostly a command held for a stretch so ramp and smoother settle
                // and the clamp engages; sometimes a lone noise item.
                v = pick_motion();
                w = pick_motion();
                hold = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 30);
                for (int k = 0; k < hold && sent < PHASE_ITEMS; k++)
                begin
                    send_tick(v, w, (k == 0) && ($urandom_range(0, 5) == 0));
                    sent++;
                    if (phase == RANDOM_PHASES / 2 && sent == drain_at)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
src/dds_pkg.sv
src/diff_drive_wheel_speed_shaper.sv
tb/sv/wheel_rpm_checker.sv
tb/sv/tb_diff_drive_wheel_speed_shaper.sv
